### design/wavhp_pkg.sv
package wavhp_pkg;

  localparam int FMT_MAX_BYTES = 256;
  localparam int FMT_MIN_BYTES = 16;
  localparam int CHUNK_HDR_BYTES = 8;
  localparam int DIV_STEPS = 31;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic CFG_CHANNELS = 1'b0;
  localparam logic CFG_RATE     = 1'b1;

  typedef enum logic [3:0] {
    PH_RIFF, PH_SIZE, PH_WAVE, PH_HDR, PH_FMT, PH_SKIP, PH_DRAIN,
    PH_MUL, PH_CHK, PH_DIV
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_TAG, OP_LEN, OP_HDR, OP_FMT, OP_SKIP
  } op_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SHORT     = 4'd1,
    ST_NO_RIFF   = 4'd2,
    ST_NO_WAVE   = 4'd3,
    ST_SIZE      = 4'd4,
    ST_OVERFLOW  = 4'd5,
    ST_BAD_FMT   = 4'd6,
    ST_DATA_1ST  = 4'd7,
    ST_NOT_PCM   = 4'd8,
    ST_CHANS     = 4'd9,
    ST_RATE      = 4'd10,
    ST_BYTE_RATE = 4'd11,
    ST_ALIGN     = 4'd12,
    ST_BITS      = 4'd13,
    ST_NO_DATA   = 4'd14
  } status_t;

  typedef struct packed {
    op_t     op;
    logic    clr_cnt;
    logic    load_rem;
    logic    sub_rem;
    logic    clr_fmt;
    logic    set_fmt_seen;
    logic    mul;
    logic    start_div;
    logic    emit;
    status_t code;
    logic    clear;
  } cmd_t;

  typedef struct packed {
    logic    cnt4;
    logic    cnt8;
    logic    tag_riff;
    logic    tag_wave;
    logic    tag_fmt;
    logic    tag_data;
    logic    size_lt4;
    logic    need_gt;
    logic    len_bad;
    logic    len_zero;
    logic    chunk_end;
    logic    rem_zero;
    logic    rem_lt8;
    logic    sub_zero;
    logic    sub_lt8;
    logic    fmt_seen;
    logic    div_busy;
    logic    out_busy;
    status_t chk_code;
  } stat_t;

endpackage

### design/wav_header_parser_unit.sv
// Channel      Dir  Width  Contents
// s_axis       in   8+1    tdata: data_byte; tlast: end_of_stream
// m_axis       out  120    tdata: status, channel_count, used_rate, frame_count,
//                          data_offset, zero pad
// cfg          in   1+32   cfg_index 0 expected_channels, 1 expected_rate
//
// One byte per cycle while the header is walked. At the data chunk header the
// input stalls through the multiply phase and the check phase; when the format
// passes, it also stalls through the divide phase (31 quotient bits, then the
// hand-off to the output register). The input also stalls while a result waits
// in the output register.
// rst is synchronous and returns the parser to the RIFF tag with both expected
// values cleared.
module wav_header_parser_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // end_of_stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] status, [19:4] channel_count, [51:20] used_rate,
  // [82:52] frame_count, [114:83] data_offset, [119:115] zero
  output logic [119:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_wdata
);
  import wavhp_pkg::*;

  cmd_t        cmd;
  stat_t       stat;
  logic [3:0]  status;
  logic [15:0] channel_count;
  logic [31:0] used_rate;
  logic [30:0] frame_count;
  logic [31:0] data_offset;

  // sequence the parse phases and the format check
  wavhp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold tags, sizes, captured format, divider and the result register
  wavhp_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (s_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .status        (status),
    .channel_count (channel_count),
    .used_rate     (used_rate),
    .frame_count   (frame_count),
    .data_offset   (data_offset)
  );

  assign m_axis_tdata = {5'd0, data_offset, frame_count, used_rate, channel_count, status};

endmodule

### design/wavhp_ctrl.sv
module wavhp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  wavhp_pkg::stat_t stat,
  output wavhp_pkg::cmd_t  cmd
);
  import wavhp_pkg::*;

  phase_t  phase, phase_next;
  logic    eos_hold, eos_hold_next;
  logic    acc, do_nc, nc_sub, has_st, to_check;
  status_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_RIFF;
      eos_hold <= 1'b0;
    end else begin
      phase    <= phase_next;
      eos_hold <= eos_hold_next;
    end
  end

  always_comb begin
    in_ready = 1'b0;
    unique case (phase)
      PH_RIFF, PH_SIZE, PH_WAVE, PH_HDR, PH_FMT, PH_SKIP: in_ready = !stat.out_busy;
      PH_DRAIN: in_ready = 1'b1;
      default:  in_ready = 1'b0;
    endcase
  end

  assign acc = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.code      = ST_OK;
    phase_next    = phase;
    eos_hold_next = eos_hold;
    do_nc         = 1'b0;
    nc_sub        = 1'b0;
    has_st        = 1'b0;
    to_check      = 1'b0;
    st            = ST_OK;

    unique case (phase)
      PH_RIFF: begin
        if (acc) begin
          cmd.op = OP_TAG;
          if (stat.cnt4) begin
            if (!stat.tag_riff) begin
              has_st = 1'b1;
              st     = ST_NO_RIFF;
            end else begin
              cmd.clr_cnt = 1'b1;
              phase_next  = PH_SIZE;
            end
          end
        end
      end
      PH_SIZE: begin
        if (acc) begin
          cmd.op = OP_LEN;
          if (stat.cnt4) begin
            if (stat.size_lt4) begin
              has_st = 1'b1;
              st     = ST_SIZE;
            end else begin
              cmd.load_rem = 1'b1;
              cmd.clr_cnt  = 1'b1;
              phase_next   = PH_WAVE;
            end
          end
        end
      end
      PH_WAVE: begin
        if (acc) begin
          cmd.op = OP_TAG;
          if (stat.cnt4) begin
            if (!stat.tag_wave) begin
              has_st = 1'b1;
              st     = ST_NO_WAVE;
            end else begin
              do_nc = 1'b1;
            end
          end
        end
      end
      PH_HDR: begin
        if (acc) begin
          cmd.op = OP_HDR;
          if (stat.cnt8) begin
            if (stat.need_gt) begin
              has_st = 1'b1;
              st     = ST_OVERFLOW;
            end else begin
              cmd.sub_rem = 1'b1;
              cmd.clr_cnt = 1'b1;
              if (stat.tag_fmt) begin
                if (stat.len_bad) begin
                  has_st = 1'b1;
                  st     = ST_BAD_FMT;
                end else begin
                  cmd.clr_fmt = 1'b1;
                  phase_next  = PH_FMT;
                end
              end else if (stat.tag_data) begin
                if (!stat.fmt_seen) begin
                  has_st = 1'b1;
                  st     = ST_DATA_1ST;
                end else begin
                  to_check      = 1'b1;
                  eos_hold_next = in_last;
                  phase_next    = PH_MUL;
                end
              end else if (stat.len_zero) begin
                do_nc  = 1'b1;
                nc_sub = 1'b1;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
        end
      end
      PH_FMT: begin
        if (acc) begin
          cmd.op = OP_FMT;
          if (stat.chunk_end) begin
            cmd.set_fmt_seen = 1'b1;
            do_nc = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        if (acc) begin
          cmd.op = OP_SKIP;
          if (stat.chunk_end) do_nc = 1'b1;
        end
      end
      PH_DRAIN: begin
        if (acc && in_last) begin
          cmd.clear  = 1'b1;
          phase_next = PH_RIFF;
        end
      end
      PH_MUL: begin
        cmd.mul    = 1'b1;
        phase_next = PH_CHK;
      end
      PH_CHK: begin
        if (stat.chk_code != ST_OK) begin
          cmd.emit   = 1'b1;
          cmd.code   = stat.chk_code;
          cmd.clear  = eos_hold;
          phase_next = eos_hold ? PH_RIFF : PH_DRAIN;
        end else begin
          cmd.start_div = 1'b1;
          phase_next    = PH_DIV;
        end
      end
      PH_DIV: begin
        if (!stat.div_busy) begin
          cmd.emit   = 1'b1;
          cmd.code   = ST_OK;
          cmd.clear  = eos_hold;
          phase_next = eos_hold ? PH_RIFF : PH_DRAIN;
        end
      end
      default: phase_next = PH_RIFF;
    endcase

    // what follows a finished chunk
    if (do_nc) begin
      if (nc_sub ? stat.sub_zero : stat.rem_zero) begin
        has_st = 1'b1;
        st     = ST_NO_DATA;
      end else if (nc_sub ? stat.sub_lt8 : stat.rem_lt8) begin
        has_st = 1'b1;
        st     = ST_SIZE;
      end else begin
        cmd.clr_cnt = 1'b1;
        phase_next  = PH_HDR;
      end
    end

    // byte-driven result, or short read on end of stream
    if (acc && phase != PH_DRAIN && !to_check && (has_st || in_last)) begin
      cmd.emit   = 1'b1;
      cmd.code   = has_st ? st : ST_SHORT;
      cmd.clear  = in_last;
      phase_next = in_last ? PH_RIFF : PH_DRAIN;
    end
  end

endmodule

### design/wavhp_dp.sv
module wavhp_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       data_byte,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_wdata,
  input  wavhp_pkg::cmd_t  cmd,
  output wavhp_pkg::stat_t stat,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0]       status,
  output logic [15:0]      channel_count,
  output logic [31:0]      used_rate,
  output logic [30:0]      frame_count,
  output logic [31:0]      data_offset
);
  import wavhp_pkg::*;

  logic [15:0]  exp_ch;
  logic [31:0]  exp_rate;
  logic [31:0]  cnt;
  logic [32:0]  rem;
  logic [31:0]  tag, len;
  logic [127:0] fmt_raw;
  logic         fmt_seen;
  logic [31:0]  offset;
  logic [47:0]  prod;
  logic [30:0]  dq;
  logic [15:0]  dr;
  logic [4:0]   dcnt;
  logic         dbusy;

  logic [31:0]  tag_new, len_new, len_base, off_cur;
  logic [32:0]  need, rem_sub;
  logic         byte_in, len_byte;
  logic [15:0]  f_fmt, f_ch, f_align, f_bits, ch_sel;
  logic [31:0]  f_rate, f_brate, rate_sel;
  logic [16:0]  dshift;
  logic         dge;
  status_t      chk;

  assign f_fmt   = fmt_raw[15:0];
  assign f_ch    = fmt_raw[31:16];
  assign f_rate  = fmt_raw[63:32];
  assign f_brate = fmt_raw[95:64];
  assign f_align = fmt_raw[111:96];
  assign f_bits  = fmt_raw[127:112];
  assign ch_sel   = (exp_ch != 16'd0) ? exp_ch : f_ch;
  assign rate_sel = (exp_rate != 32'd0) ? exp_rate : f_rate;

  assign byte_in  = (cmd.op != OP_NONE);
  assign len_byte = (cmd.op == OP_LEN) || (cmd.op == OP_HDR && cnt[2]);
  assign tag_new  = {tag[23:0], data_byte};
  assign len_base = (cnt[1:0] == 2'd0) ? 32'd0 : len;
  assign len_new  = len_base | ({24'd0, data_byte} << {cnt[1:0], 3'b000});
  assign need     = 33'(CHUNK_HDR_BYTES) + {1'b0, len_new};
  assign rem_sub  = rem - need;
  assign off_cur  = byte_in ? offset + 32'd1 : offset;

  always_comb begin
    chk = ST_OK;
    priority if (f_fmt != 16'd1)                        chk = ST_NOT_PCM;
    else if (f_ch == 16'd0 || f_ch != ch_sel)           chk = ST_CHANS;
    else if (f_rate != rate_sel)                        chk = ST_RATE;
    else if ({17'd0, f_brate} != {prod, 1'b0})          chk = ST_BYTE_RATE;
    else if ({1'b0, f_align} != {ch_sel, 1'b0})         chk = ST_ALIGN;
    else if (f_bits != 16'd16)                          chk = ST_BITS;
  end

  always_comb begin
    stat           = '0;
    stat.cnt4      = (cnt == 32'd3);
    stat.cnt8      = (cnt == 32'd7);
    stat.tag_riff  = (tag_new == TAG_RIFF);
    stat.tag_wave  = (tag_new == TAG_WAVE);
    stat.tag_fmt   = (tag == TAG_FMT);
    stat.tag_data  = (tag == TAG_DATA);
    stat.size_lt4  = (len_new < 32'd4);
    stat.need_gt   = (need > rem);
    stat.len_bad   = (len_new < 32'(FMT_MIN_BYTES)) || (len_new > 32'(FMT_MAX_BYTES));
    stat.len_zero  = (len_new == 32'd0);
    stat.chunk_end = ({1'b0, cnt} + 33'd1 >= {1'b0, len});
    stat.rem_zero  = (rem == 33'd0);
    stat.rem_lt8   = (rem < 33'(CHUNK_HDR_BYTES));
    stat.sub_zero  = (rem_sub == 33'd0);
    stat.sub_lt8   = (rem_sub < 33'(CHUNK_HDR_BYTES));
    stat.fmt_seen  = fmt_seen;
    stat.div_busy  = dbusy;
    stat.out_busy  = out_valid;
    stat.chk_code  = chk;
  end

  assign dshift = {dr, dq[30]};
  assign dge    = (dshift >= {1'b0, ch_sel});

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_ch   <= '0;
      exp_rate <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CHANNELS) exp_ch <= cfg_wdata[15:0];
      else                           exp_rate <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt      <= '0;
      rem      <= '0;
      fmt_seen <= 1'b0;
      offset   <= '0;
    end else begin
      if (cmd.clr_cnt)  cnt <= '0;
      else if (byte_in) cnt <= cnt + 32'd1;
      if (cmd.load_rem)     rem <= {1'b0, len_new} - 33'd4;
      else if (cmd.sub_rem) rem <= rem_sub;
      if (cmd.set_fmt_seen) fmt_seen <= 1'b1;
      offset <= off_cur;
    end
  end

  // payload holders
  always_ff @(posedge clk) begin
    if (cmd.op == OP_TAG || (cmd.op == OP_HDR && !cnt[2])) tag <= tag_new;
    if (len_byte) len <= len_new;
    if (cmd.clr_fmt) fmt_raw <= '0;
    else if (cmd.op == OP_FMT && cnt < 32'd16) fmt_raw[{cnt[3:0], 3'b000} +: 8] <= data_byte;
    if (cmd.mul) prod <= ch_sel * rate_sel;
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      dcnt  <= '0;
    end else if (cmd.start_div) begin
      dbusy <= 1'b1;
      dcnt  <= 5'(DIV_STEPS);
    end else if (dbusy) begin
      dcnt <= dcnt - 5'd1;
      if (dcnt == 5'd1) dbusy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      dq <= len[31:1];
      dr <= '0;
    end else if (dbusy) begin
      dq <= {dq[29:0], dge};
      dr <= dge ? 16'(dshift - {1'b0, ch_sel}) : dshift[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= cmd.code;
      if (cmd.code == ST_OK) begin
        channel_count <= ch_sel;
        used_rate     <= rate_sel;
        frame_count   <= dq;
        data_offset   <= off_cur;
      end else begin
        channel_count <= '0;
        used_rate     <= '0;
        frame_count   <= '0;
        data_offset   <= '0;
      end
    end
  end

endmodule
